FILE: rtl/core/nfkvt_pkg.sv
`default_nettype none

package nfkvt_pkg;

  // Table capacity and derived widths.
  localparam int ENTRIES = 255;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LEN_W   = $clog2(ENTRIES + 1);
  localparam int POS_W   = 8;
  localparam int WORD_W  = 32;
  localparam int ENTRY_W = 4 * WORD_W;

  typedef enum logic [2:0] {
    REQ_LOOKUP   = 3'd0,
    REQ_APPEND   = 3'd1,
    REQ_CLEAR    = 3'd2,
    REQ_TRUNCATE = 3'd3,
    REQ_READ     = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic                     found;
    logic [POS_W-1:0]         entry_position;
    logic signed [WORD_W-1:0] out_first;
    logic signed [WORD_W-1:0] out_second;
    logic signed [WORD_W-1:0] out_third;
    stat_t                    status;
  } res_t;

  // Result without entry values.
  function automatic res_t plain_res(logic [LEN_W-1:0] pos, stat_t st);
    res_t r;
    r.found          = 1'b0;
    r.entry_position = POS_W'(pos);
    r.out_first      = '0;
    r.out_second     = '0;
    r.out_third      = '0;
    r.status         = st;
    return r;
  endfunction

  // Result carrying the values of a stored entry.
  function automatic res_t entry_res(logic [LEN_W-1:0] pos, logic [ENTRY_W-1:0] ent);
    res_t r;
    r.found          = 1'b1;
    r.entry_position = POS_W'(pos);
    r.out_first      = ent[3*WORD_W-1:2*WORD_W];
    r.out_second     = ent[2*WORD_W-1:WORD_W];
    r.out_third      = ent[WORD_W-1:0];
    r.status         = STAT_OK;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nfkvt_ifs.sv
`default_nettype none

interface nfkvt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] key;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic signed [31:0] third_value;
  logic [7:0]         position;

  modport source (
    output valid, req_type, key, first_value, second_value, third_value, position,
    input  ready
  );
  modport sink (
    input  valid, req_type, key, first_value, second_value, third_value, position,
    output ready
  );
endinterface

interface nfkvt_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [7:0]         entry_position;
  logic signed [31:0] out_first;
  logic signed [31:0] out_second;
  logic signed [31:0] out_third;
  logic [1:0]         status;

  modport source (
    output valid, found, entry_position, out_first, out_second, out_third, status,
    input  ready
  );
  modport sink (
    input  valid, found, entry_position, out_first, out_second, out_third, status,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/newest_first_key_value_table.sv
// Append, clear, truncate, bad reads and lookups on an empty table go straight to the done state;
// a valid read passes through the read state, and a lookup scans until it hits or reaches the oldest entry.
// One request at a time: a new request is taken only once the sequencer is back in idle.
// A full lookup miss walks every stored entry through the RAM read port, one a cycle.
// Reset (rst_n low, synchronous) empties the table and drops any pending response.
`default_nettype none

// Newest-first key/value table.
//
// Entries live in one RAM row each: key and three values side by side.
// The sequencer keeps the current length in a register; positions 1 to
// the length are the valid rows, stored at addresses 0 to length - 1.
// An append writes the row at the current length in the cycle the request
// is taken. A lookup reads the newest row first and then one older row per
// cycle, comparing each returned key with the request key while the next
// read is already issued; the first hit is the most recent match. A read by
// position takes one RAM access. The response then waits in the output
// register, so the sequencer can return to idle while the sink stalls.
module newest_first_key_value_table import nfkvt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nfkvt_req_if.sink   in_req,
  nfkvt_rsp_if.source out_rsp
);

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               res_valid;
  logic               res_ready;
  res_t               res;

  // Entry storage; contents are undefined until appended.
  nfkvt_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (ENTRIES),
    .AWIDTH (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request decode, length bookkeeping and the newest-first scan.
  nfkvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Response holding register toward the sink.
  nfkvt_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/core/nfkvt_ram.sv
`default_nettype none

// Simple dual-port synchronous RAM, one write and one registered read port.
module nfkvt_ram #(
  parameter int WIDTH  = 128,
  parameter int DEPTH  = 255,
  parameter int AWIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AWIDTH-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [AWIDTH-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nfkvt_ctrl.sv
`default_nettype none

// Request sequencer: owns the table length, drives the entry RAM and
// walks it newest first for a lookup.
module nfkvt_ctrl import nfkvt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  nfkvt_req_if.sink               in_req,
  output logic                    wr_en,
  output logic [ADDR_W-1:0]       wr_addr,
  output logic [ENTRY_W-1:0]      wr_data,
  output logic                    rd_en,
  output logic [ADDR_W-1:0]       rd_addr,
  input  wire logic [ENTRY_W-1:0] rd_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output res_t                    res
);

  fsm_t              state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  scan_r, scan_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  res_t              res_r, res_nxt;

  logic             fire;
  req_code_t        code;
  logic [LEN_W-1:0] pos_in;
  logic             pos_over;
  logic             read_ok;
  logic             key_hit;
  logic             scan_last;

  assign in_req.ready = (state_r == S_IDLE);
  assign fire         = in_req.valid && in_req.ready;
  assign code         = req_code_t'(in_req.req_type);
  assign pos_in       = LEN_W'(in_req.position);
  assign pos_over     = pos_in > len_r;
  assign read_ok      = (pos_in != '0) && !pos_over;
  assign key_hit      = rd_data[ENTRY_W-1:3*WORD_W] == key_r;
  assign scan_last    = scan_r == LEN_W'(1);

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          if (code == REQ_LOOKUP && len_r != '0) begin
            state_nxt = S_SCAN;
          end else if (code == REQ_READ && read_ok) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (key_hit || scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = ADDR_W'(len_r);
    wr_data  = {in_req.key, in_req.first_value, in_req.second_value, in_req.third_value};
    rd_en    = 1'b0;
    rd_addr  = '0;
    len_nxt  = len_r;
    scan_nxt = scan_r;
    key_nxt  = key_r;
    res_nxt  = res_r;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          key_nxt = in_req.key;
          case (code)
            REQ_LOOKUP: begin
              res_nxt  = plain_res('0, STAT_OK);
              rd_en    = len_r != '0;
              rd_addr  = ADDR_W'(len_r - 1'b1);
              scan_nxt = len_r;
            end
            REQ_APPEND: begin
              if (len_r >= LEN_W'(ENTRIES)) begin
                res_nxt = plain_res(len_r, STAT_FULL);
              end else begin
                wr_en   = 1'b1;
                len_nxt = LEN_W'(len_r + 1'b1);
                res_nxt = plain_res(LEN_W'(len_r + 1'b1), STAT_OK);
              end
            end
            REQ_CLEAR: begin
              len_nxt = '0;
              res_nxt = plain_res('0, STAT_OK);
            end
            REQ_TRUNCATE: begin
              if (pos_over) begin
                res_nxt = plain_res(len_r, STAT_RANGE);
              end else begin
                len_nxt = pos_in;
                res_nxt = plain_res(pos_in, STAT_OK);
              end
            end
            REQ_READ: begin
              res_nxt = plain_res(len_r, read_ok ? STAT_OK : STAT_RANGE);
              rd_en   = read_ok;
              rd_addr = ADDR_W'(pos_in - 1'b1);
            end
            default: begin
              res_nxt = plain_res(len_r, STAT_OK);
            end
          endcase
        end
      end
      S_SCAN: begin
        // rd_data holds the entry at position scan_r.
        if (key_hit) begin
          res_nxt = entry_res(scan_r, rd_data);
        end else if (!scan_last) begin
          rd_en    = 1'b1;
          rd_addr  = ADDR_W'(scan_r - 2'd2);
          scan_nxt = LEN_W'(scan_r - 1'b1);
        end
      end
      S_READ: begin
        res_nxt = entry_res(len_r, rd_data);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    key_r  <= key_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/nfkvt_outreg.sv
`default_nettype none

// Output register: holds one response until the sink takes it.
module nfkvt_outreg import nfkvt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  output logic      res_ready,
  input  res_t      res,
  nfkvt_rsp_if.source out_rsp
);

  logic valid_r, valid_nxt;
  res_t data_r, data_nxt;

  assign res_ready = !valid_r || out_rsp.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res_ready) begin
      valid_nxt = res_valid;
      if (res_valid) begin
        data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_rsp.valid          = valid_r;
  assign out_rsp.found          = data_r.found;
  assign out_rsp.entry_position = data_r.entry_position;
  assign out_rsp.out_first      = data_r.out_first;
  assign out_rsp.out_second     = data_r.out_second;
  assign out_rsp.out_third      = data_r.out_third;
  assign out_rsp.status         = data_r.status;

endmodule

`default_nettype wire

FILE: rtl/core/nfkvt_checker.sv
`default_nettype none

module nfkvt_checker import nfkvt_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        found,
  input wire logic [31:0] out_first,
  input wire logic [31:0] out_second,
  input wire logic [31:0] out_third,
  input wire logic [1:0]  status
);

  // A stalled response stays valid and keeps its found flag, status and first value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(status)
      && $stable(out_first))
    else $error("stalled response changed");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  // A hit or valid read always reports success.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> status == STAT_OK)
    else $error("found response with error status");

  // Without a hit, value fields are zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> out_first == '0 && out_second == '0 && out_third == '0)
    else $error("miss response carries values");

  // Reset drops any pending response.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind newest_first_key_value_table nfkvt_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .found      (out_rsp.found),
  .out_first  (out_rsp.out_first),
  .out_second (out_rsp.out_second),
  .out_third  (out_rsp.out_third),
  .status     (out_rsp.status)
);

`default_nettype wire
